// ===== design/grmd_pkg.sv =====
// Shared types and constants for the grid ray march DDA unit.
// Used by the datapath, controller and top level.
package grmd_pkg;

	localparam int MapCellsDef = 4096;

	localparam logic [6:0]  GridWidthRst  = 7'd64;
	localparam logic [6:0]  GridHeightRst = 7'd64;
	localparam logic [8:0]  CellSizeRst   = 9'd16;
	localparam logic [19:0] MaxLengthRst  = 20'd131072;

	localparam logic [19:0] PosMax = 20'hFFFFF;

	typedef enum logic [1:0] {
		REG_GRID_WIDTH  = 2'd0,
		REG_GRID_HEIGHT = 2'd1,
		REG_CELL_SIZE   = 2'd2,
		REG_MAX_LENGTH  = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_CAST  = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		DV_COLX,
		DV_ROWY,
		DV_SIDEX,
		DV_DELX,
		DV_SIDEY,
		DV_DELY
	} div_sel_t;

	typedef struct packed {
		logic     clr_we;
		logic     map_we;
		logic     load_item;
		logic     div_start;
		logic     div_store;
		div_sel_t div_sel;
		logic     step;
		logic     look;
		logic     set_hit;
		logic     mul;
		logic     load_out;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic div_done;
		logic div_busy;
		logic ax_nz;
		logic ay_nz;
		logic past_max;
		logic wall;
	} stat_t;

endpackage

// ===== design/grmd_div.sv =====
// Radix-2 restoring divider, 32-bit dividend by 17-bit divisor.
// One quotient bit per cycle; depends on nothing else.
module grmd_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [16:0] divisor,
	output logic        busy,
	output logic        done,
	output logic [31:0] quo,
	output logic [16:0] rem
);
	logic        busy_q, done_q;
	logic [4:0]  cnt_q;
	logic [31:0] acc_q;
	logic [16:0] rem_q, dvs_q;
	logic [17:0] trial, diff;
	logic        ge;

	assign trial = {rem_q, acc_q[31]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			acc_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			acc_q <= {acc_q[30:0], ge};
			rem_q <= ge ? diff[16:0] : trial[16:0];
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = acc_q;
	assign rem  = rem_q;

endmodule

// ===== design/grmd_dp.sv =====
// Datapath: configuration, wall map memory, divider, DDA registers, end point.
// Depends on grmd_pkg and grmd_div; driven by grmd_ctrl commands.
module grmd_dp import grmd_pkg::*; #(
	parameter int MAP_CELLS = MapCellsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output stat_t       st,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [19:0] cfg_data,
	input  logic [11:0] cell_index,
	input  logic        wall_bit,
	input  logic [19:0] start_x,
	input  logic [19:0] start_y,
	input  logic signed [15:0] dir_x,
	input  logic signed [15:0] dir_y,
	output logic [19:0] ray_length,
	output logic [19:0] end_x,
	output logic [19:0] end_y,
	output logic        hit_found
);
	localparam int AW = $clog2(MAP_CELLS);

	logic [6:0]  gw_q, gh_q;
	logic [8:0]  cs_q;
	logic [19:0] maxlen_q;

	logic [19:0] sx_q, sy_q;
	logic signed [15:0] dx_q, dy_q;
	logic [15:0] ax, ay;
	logic [8:0]  cs_eff;
	logic [16:0] span;
	logic [16:0] remx_q, remy_q, gapx, gapy;
	logic signed [15:0] col_q, row_q;
	logic [31:0] sidex_q, sidey_q, delx_q, dely_q, cur_q;
	logic [19:0] len_q;
	logic        hit_q;
	logic [35:0] prodx_q, prody_q;
	logic [21:0] offx, offy;
	logic [22:0] sumx, sumy;
	logic [19:0] ex, ey;

	logic        mem_q [MAP_CELLS];
	logic        rd_q, inb_q, inb;
	logic [AW-1:0] clr_q;
	logic [13:0] idx;

	logic [31:0] dvd;
	logic [16:0] dvs, rem;
	logic [31:0] quo;
	logic        dbusy, ddone, stepx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gw_q     <= GridWidthRst;
			gh_q     <= GridHeightRst;
			cs_q     <= CellSizeRst;
			maxlen_q <= MaxLengthRst;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_GRID_WIDTH:  gw_q     <= cfg_data[6:0];
				REG_GRID_HEIGHT: gh_q     <= cfg_data[6:0];
				REG_CELL_SIZE:   cs_q     <= cfg_data[8:0];
				REG_MAX_LENGTH:  maxlen_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cs_eff = (cs_q == 9'd0) ? 9'd1 : cs_q;
	assign span   = {cs_eff, 8'b0};
	assign ax     = dx_q[15] ? 16'(~dx_q + 16'sd1) : 16'(dx_q);
	assign ay     = dy_q[15] ? 16'(~dy_q + 16'sd1) : 16'(dy_q);
	assign gapx   = dx_q[15] ? remx_q : span - remx_q;
	assign gapy   = dy_q[15] ? remy_q : span - remy_q;

	always_comb begin
		dvd = {12'b0, sx_q};
		dvs = span;
		case (cmd.div_sel)
			DV_COLX:  begin dvd = {12'b0, sx_q};        dvs = span; end
			DV_ROWY:  begin dvd = {12'b0, sy_q};        dvs = span; end
			DV_SIDEX: begin dvd = {1'b0, gapx, 14'b0};  dvs = {1'b0, ax}; end
			DV_DELX:  begin dvd = {1'b0, span, 14'b0};  dvs = {1'b0, ax}; end
			DV_SIDEY: begin dvd = {1'b0, gapy, 14'b0};  dvs = {1'b0, ay}; end
			DV_DELY:  begin dvd = {1'b0, span, 14'b0};  dvs = {1'b0, ay}; end
			default: ;
		endcase
	end

	grmd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.busy     (dbusy),
		.done     (ddone),
		.quo      (quo),
		.rem      (rem)
	);

	assign stepx = (ax != 16'd0) && ((ay == 16'd0) || (sidex_q < sidey_q));

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			sx_q  <= start_x;
			sy_q  <= start_y;
			dx_q  <= dir_x;
			dy_q  <= dir_y;
			len_q <= maxlen_q;
			hit_q <= 1'b0;
		end
		if (cmd.div_store) begin
			case (cmd.div_sel)
				DV_COLX:  begin col_q <= 16'(quo); remx_q <= rem; end
				DV_ROWY:  begin row_q <= 16'(quo); remy_q <= rem; end
				DV_SIDEX: sidex_q <= quo;
				DV_DELX:  delx_q  <= quo;
				DV_SIDEY: sidey_q <= quo;
				DV_DELY:  dely_q  <= quo;
				default: ;
			endcase
		end
		if (cmd.step) begin
			if (stepx) begin
				col_q   <= dx_q[15] ? col_q - 16'sd1 : col_q + 16'sd1;
				cur_q   <= sidex_q;
				sidex_q <= sidex_q + delx_q;
			end else begin
				row_q   <= dy_q[15] ? row_q - 16'sd1 : row_q + 16'sd1;
				cur_q   <= sidey_q;
				sidey_q <= sidey_q + dely_q;
			end
		end
		if (cmd.set_hit) begin
			len_q <= cur_q[19:0];
			hit_q <= 1'b1;
		end
		if (cmd.mul) begin
			prodx_q <= 36'(ax) * 36'(len_q);
			prody_q <= 36'(ay) * 36'(len_q);
		end
		if (cmd.load_out) begin
			ray_length <= len_q;
			end_x      <= ex;
			end_y      <= ey;
			hit_found  <= hit_q;
		end
	end

	assign offx = prodx_q[35:14];
	assign offy = prody_q[35:14];
	assign sumx = {3'b0, sx_q} + {1'b0, offx};
	assign sumy = {3'b0, sy_q} + {1'b0, offy};

	always_comb begin
		if (dx_q[15]) ex = (offx > {2'b0, sx_q}) ? 20'd0 : 20'(sumx - 23'(offx) - 23'(offx));
		else          ex = (sumx > {3'b0, PosMax}) ? PosMax : sumx[19:0];
		if (dy_q[15]) ey = (offy > {2'b0, sy_q}) ? 20'd0 : 20'(sumy - 23'(offy) - 23'(offy));
		else          ey = (sumy > {3'b0, PosMax}) ? PosMax : sumy[19:0];
	end

	assign idx = 14'(row_q[6:0]) * 14'(gw_q) + 14'(col_q[6:0]);
	assign inb = !col_q[15] && !row_q[15]
		&& (col_q < $signed({9'b0, gw_q})) && (row_q < $signed({9'b0, gh_q}))
		&& (32'(idx) < 32'(MAP_CELLS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (cmd.clr_we) clr_q <= clr_q + AW'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_we) mem_q[clr_q] <= 1'b0;
		else if (cmd.map_we && (32'(cell_index) < 32'(MAP_CELLS)))
			mem_q[AW'(cell_index)] <= wall_bit;
		if (cmd.look) begin
			rd_q  <= mem_q[AW'(idx)];
			inb_q <= inb;
		end
	end

	assign st.clr_last = (clr_q == AW'(MAP_CELLS - 1));
	assign st.div_done = ddone;
	assign st.div_busy = dbusy;
	assign st.ax_nz    = (ax != 16'd0);
	assign st.ay_nz    = (ay != 16'd0);
	assign st.past_max = (cur_q > {12'b0, maxlen_q});
	assign st.wall     = inb_q && rd_q;

endmodule

// ===== design/grmd_ctrl.sv =====
// Controller state machine: clearing pass, division sequence, DDA walk, result.
// Depends on grmd_pkg; drives grmd_dp through cmd_t and reads stat_t.
module grmd_ctrl import grmd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  logic  opcode,
	output logic  out_valid,
	input  logic  out_ready,
	output cmd_t  cmd,
	input  stat_t st
);
	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_DIV_GO, S_DIV_WAIT, S_STEP, S_LOOK, S_TEST, S_MUL, S_FIN
	} state_t;

	state_t   state_q;
	div_sel_t sel_q;
	logic     out_valid_q, acc;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign acc       = in_valid && in_ready;

	always_comb begin
		cmd           = '0;
		cmd.div_sel   = sel_q;
		cmd.clr_we    = (state_q == S_CLEAR);
		cmd.map_we    = acc && (op_t'(opcode) == OP_WRITE);
		cmd.load_item = acc && (op_t'(opcode) == OP_CAST);
		cmd.div_start = (state_q == S_DIV_GO);
		cmd.div_store = (state_q == S_DIV_WAIT) && st.div_done;
		cmd.step      = (state_q == S_STEP);
		cmd.look      = (state_q == S_LOOK);
		cmd.set_hit   = (state_q == S_TEST) && st.wall;
		cmd.mul       = (state_q == S_MUL);
		cmd.load_out  = (state_q == S_FIN) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			sel_q       <= DV_COLX;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_CLEAR: if (st.clr_last) state_q <= S_IDLE;
				S_IDLE: begin
					if (acc && (op_t'(opcode) == OP_CAST)) begin
						sel_q   <= DV_COLX;
						state_q <= S_DIV_GO;
					end
				end
				S_DIV_GO: state_q <= S_DIV_WAIT;
				S_DIV_WAIT: begin
					if (st.div_done) begin
						state_q <= S_DIV_GO;
						case (sel_q)
							DV_COLX: sel_q <= DV_ROWY;
							DV_ROWY: begin
								if (st.ax_nz)      sel_q <= DV_SIDEX;
								else if (st.ay_nz) sel_q <= DV_SIDEY;
								else               state_q <= S_MUL;
							end
							DV_SIDEX: sel_q <= DV_DELX;
							DV_DELX: begin
								if (st.ay_nz) sel_q <= DV_SIDEY;
								else          state_q <= S_STEP;
							end
							DV_SIDEY: sel_q <= DV_DELY;
							DV_DELY:  state_q <= S_STEP;
							default:  state_q <= S_STEP;
						endcase
					end
				end
				S_STEP: state_q <= S_LOOK;
				S_LOOK: state_q <= st.past_max ? S_MUL : S_TEST;
				S_TEST: state_q <= st.wall ? S_MUL : S_STEP;
				S_MUL:  state_q <= S_FIN;
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !st.div_busy) else $error("divider started while busy");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready)) else $error("result overwritten");
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !cmd.map_we && !cmd.load_item) else $error("item during clear");
	a_hit_stops: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.set_hit |=> (state_q == S_MUL)) else $error("walk continued after hit");

endmodule

// ===== design/grid_ray_march_dda_unit.sv =====
// Grid ray march DDA unit: top level joining controller and datapath.
// Depends on grmd_pkg, grmd_ctrl, grmd_dp (which holds grmd_div).
// After reset a clearing pass empties the wall map; items are not taken
// until it ends, configuration writes are. A cast runs on one shared
// divider: two divisions for the start cell, plus two per nonzero direction
// component, then for each grid line crossed a step, a map read and a test,
// then a product and the result load. One item is in work at a time; the
// result register lets the next item be taken while a result waits.
module grid_ray_march_dda_unit import grmd_pkg::*; #(
	parameter int MAP_CELLS = MapCellsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [19:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        opcode,
	input  logic [11:0] cell_index,
	input  logic        wall_bit,
	input  logic [19:0] start_x,
	input  logic [19:0] start_y,
	input  logic signed [15:0] dir_x,
	input  logic signed [15:0] dir_y,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [19:0] ray_length,
	output logic [19:0] end_x,
	output logic [19:0] end_y,
	output logic        hit_found
);
	cmd_t  cmd;
	stat_t st;

	grmd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.st        (st)
	);

	grmd_dp #(.MAP_CELLS(MAP_CELLS)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cell_index (cell_index),
		.wall_bit   (wall_bit),
		.start_x    (start_x),
		.start_y    (start_y),
		.dir_x      (dir_x),
		.dir_y      (dir_y),
		.ray_length (ray_length),
		.end_x      (end_x),
		.end_y      (end_y),
		.hit_found  (hit_found)
	);

endmodule

// ===== tb/tb_grid_ray_march_dda_unit.sv =====
// Testbench for grid_ray_march_dda_unit: directed and random map writes and ray casts,
// checked against a behavioral DDA walk kept in the testbench.
// Depends on grmd_pkg and the design files under design/.
module tb_grid_ray_march_dda_unit;
	import grmd_pkg::*;

	typedef struct {
		logic [19:0] len;
		logic [19:0] ex;
		logic [19:0] ey;
		logic        hit;
	} ray_res_t;

	localparam int MAP_CELLS = 4096;
	localparam int STALL_LIMIT = 200000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [19:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic        opcode;
	logic [11:0] cell_index;
	logic        wall_bit;
	logic [19:0] start_x;
	logic [19:0] start_y;
	logic signed [15:0] dir_x;
	logic signed [15:0] dir_y;
	logic        out_valid;
	logic        out_ready;
	logic [19:0] ray_length;
	logic [19:0] end_x;
	logic [19:0] end_y;
	logic        hit_found;

	grid_ray_march_dda_unit dut (.*);

	bit       wall_mem [MAP_CELLS];
	longint   gw, gh, cell_sz, max_len;
	ray_res_t pending_rays [$];
	int       err_cnt;
	int       burst_left;
	int       idle_cycles;
	int       stall_mode;
	int       stall_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit cell_is_wall(longint col, longint row);
		longint idx;
		if (col < 0 || row < 0) return 1'b0;
		if (col >= gw || row >= gh) return 1'b0;
		idx = row * gw + col;
		if (idx >= MAP_CELLS) return 1'b0;
		return wall_mem[idx];
	endfunction

	function automatic logic [19:0] end_coord(longint start, longint d, longint len);
		longint mag, off, e;
		mag = (d < 0) ? -d : d;
		off = (mag * len) >>> 14;
		if (d < 0) return (off > start) ? 20'd0 : 20'(start - off);
		e = start + off;
		return (e > 1048575) ? PosMax : 20'(e);
	endfunction

	function automatic ray_res_t trace_ray(logic [19:0] sx, logic [19:0] sy,
			logic signed [15:0] dx, logic signed [15:0] dy);
		longint cs, span, ax, ay, len, col, row, gap, cur;
		longint side_x, side_y, del_x, del_y, stc, str, lx, ly;
		bit hit;
		ray_res_t r;
		lx = longint'(dx);
		ly = longint'(dy);
		cs = (cell_sz == 0) ? 1 : cell_sz;
		span = cs << 8;
		ax = (lx < 0) ? -lx : lx;
		ay = (ly < 0) ? -ly : ly;
		len = max_len;
		hit = 1'b0;
		side_x = 0; side_y = 0; del_x = 0; del_y = 0; stc = 0; str = 0;
		if (ax != 0 || ay != 0) begin
			col = longint'(sx) / span;
			row = longint'(sy) / span;
			if (ax != 0) begin
				gap = (lx > 0) ? (col + 1) * span - sx : sx - col * span;
				side_x = gap * 16384 / ax;
				del_x = span * 16384 / ax;
				stc = (lx > 0) ? 1 : -1;
			end
			if (ay != 0) begin
				gap = (ly > 0) ? (row + 1) * span - sy : sy - row * span;
				side_y = gap * 16384 / ay;
				del_y = span * 16384 / ay;
				str = (ly > 0) ? 1 : -1;
			end
			while (1) begin
				if (ax != 0 && (ay == 0 || side_x < side_y)) begin
					col += stc;
					cur = side_x;
					side_x += del_x;
				end else begin
					row += str;
					cur = side_y;
					side_y += del_y;
				end
				if (cur > max_len) break;
				if (cell_is_wall(col, row)) begin
					len = cur;
					hit = 1'b1;
					break;
				end
			end
		end
		r.len = 20'(len);
		r.ex = end_coord(longint'(sx), lx, len);
		r.ey = end_coord(longint'(sy), ly, len);
		r.hit = hit;
		return r;
	endfunction

	task automatic report(string what, logic [19:0] got, logic [19:0] want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		err_cnt++;
	endtask

	// receiver stall pattern and result check
	always @(posedge clk) begin
		ray_res_t w;
		if (arst_n && out_valid && out_ready) begin
			if (pending_rays.size() == 0) begin
				$display("unexpected result transfer: length %0d", ray_length);
				err_cnt++;
			end else begin
				w = pending_rays.pop_front();
				if (ray_length !== w.len) report("ray_length", ray_length, w.len);
				if (end_x !== w.ex) report("end_x", end_x, w.ex);
				if (end_y !== w.ey) report("end_y", end_y, w.ey);
				if (hit_found !== w.hit) report("hit_found", 20'(hit_found), 20'(w.hit));
			end
		end
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(5, 300);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 9) < 7);
			2: out_ready <= ($urandom_range(0, 9) < 2);
			default: out_ready <= stall_left[3];
		endcase
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic send_item(op_t op, logic [11:0] idx, logic wb, logic [19:0] sx,
			logic [19:0] sy, logic signed [15:0] dx, logic signed [15:0] dy);
		opcode <= op;
		cell_index <= idx;
		wall_bit <= wb;
		start_x <= sx;
		start_y <= sy;
		dir_x <= dx;
		dir_y <= dy;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (op == OP_CAST) pending_rays.push_back(trace_ray(sx, sy, dx, dy));
		else wall_mem[idx] = wb;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(0, 8);
		end else begin
			burst_left--;
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_rays.size() != 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic cfg_write(cfg_reg_t idx, logic [19:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_GRID_WIDTH:  gw = val[6:0];
			REG_GRID_HEIGHT: gh = val[6:0];
			REG_CELL_SIZE:   cell_sz = val[8:0];
			default:         max_len = val;
		endcase
	endtask

	task automatic cast(logic [19:0] sx, logic [19:0] sy, int dx, int dy);
		send_item(OP_CAST, 12'd0, 1'b0, sx, sy, 16'(dx), 16'(dy));
	endtask

	task automatic put_wall(int idx, bit wb);
		send_item(OP_WRITE, 12'(idx), wb, 20'd0, 20'd0, 16'sd0, 16'sd0);
	endtask

	task automatic test_default_casts();
		put_wall(3, 1'b1);
		put_wall(64 * 3, 1'b1);
		put_wall(4095, 1'b1);
		cast(20'd2048, 20'd2048, 0, 0);
		cast(20'd2048, 20'd2048, 16384, 0);
		cast(20'd2048, 20'd2048, 0, 16384);
		cast(20'd2048, 20'd2048, -16384, 0);
		cast(20'd2048, 20'd2048, 0, -16384);
		cast(20'd2048, 20'd2048, 11585, 11585);
		cast(20'd0, 20'd0, 16384, 16384);
		cast(20'd1000, 20'd900, -16384, -16384);
		cast(20'd15000, 20'd1000, -16384, 1);
		cast(20'hFFFFF, 20'hFFFFF, 16384, 16384);
		cast(20'd1000, 20'd1000, 16384, -16384);
		put_wall(3, 1'b0);
		cast(20'd2048, 20'd2048, 16384, 0);
		drain();
	endtask

	task automatic test_extreme_config();
		cfg_write(REG_MAX_LENGTH, 20'd0);
		cast(20'd2048, 20'd2048, 0, 16384);
		drain();
		cfg_write(REG_GRID_WIDTH, 20'd1);
		cfg_write(REG_GRID_HEIGHT, 20'd1);
		cfg_write(REG_CELL_SIZE, 20'd256);
		cfg_write(REG_MAX_LENGTH, 20'hFFFFF);
		put_wall(0, 1'b1);
		cast(20'd70000, 20'd1000, -16384, 0);
		cast(20'd1000, 20'd1000, 9000, -13000);
		drain();
		cfg_write(REG_GRID_WIDTH, 20'd64);
		cfg_write(REG_GRID_HEIGHT, 20'd64);
		cfg_write(REG_CELL_SIZE, 20'd1);
		put_wall(64 * 63 + 63, 1'b1);
		cast(20'd100, 20'd100, 16384, 16384);
		cast(20'd300, 20'd50, 2, 16383);
		drain();
	endtask

	task automatic rand_config();
		int cs, w, h;
		drain();
		w = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 64);
		h = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(1, 64);
		cs = ($urandom_range(0, 9) == 0) ? 256 : $urandom_range(4, 48);
		cfg_write(REG_GRID_WIDTH, 20'(w));
		cfg_write(REG_GRID_HEIGHT, 20'(h));
		cfg_write(REG_CELL_SIZE, 20'(cs));
		case ($urandom_range(0, 9))
			0: cfg_write(REG_MAX_LENGTH, 20'd0);
			1: cfg_write(REG_MAX_LENGTH, 20'(cs * 256 * 120));
			default: cfg_write(REG_MAX_LENGTH, 20'($urandom_range(256, cs * 256 * 24)));
		endcase
	endtask

	function automatic int rand_dir();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 16384;
			2: return -16384;
			default: return $urandom_range(0, 32768) - 16384;
		endcase
	endfunction

	task automatic test_random(int n_items);
		longint area, ext;
		for (int i = 0; i < n_items; i++) begin
			if (i % 120 == 0) rand_config();
			area = gw * gh;
			ext = gw * cell_sz * 256;
			if ($urandom_range(0, 9) < 3) begin
				if ($urandom_range(0, 4) == 0 || area > MAP_CELLS)
					put_wall($urandom_range(0, MAP_CELLS - 1), 1'($urandom_range(0, 1)));
				else
					put_wall($urandom_range(0, int'(area) - 1), $urandom_range(0, 3) != 0);
			end else if ($urandom_range(0, 9) == 0) begin
				cast(20'($urandom), 20'($urandom), rand_dir(), rand_dir());
			end else begin
				cast(20'($urandom_range(0, int'((ext > 1048575) ? 1048575 : ext))),
					20'($urandom_range(0, int'((gh * cell_sz * 256 > 1048575) ?
						1048575 : gh * cell_sz * 256))),
					rand_dir(), rand_dir());
			end
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_GRID_WIDTH;
		cfg_data = 20'd0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		opcode = OP_WRITE;
		cell_index = 12'd0;
		wall_bit = 1'b0;
		start_x = 20'd0;
		start_y = 20'd0;
		dir_x = 16'sd0;
		dir_y = 16'sd0;
		err_cnt = 0;
		burst_left = 0;
		idle_cycles = 0;
		stall_mode = 0;
		stall_left = 0;
		gw = GridWidthRst;
		gh = GridHeightRst;
		cell_sz = CellSizeRst;
		max_len = MaxLengthRst;
		foreach (wall_mem[i]) wall_mem[i] = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_casts();
		test_extreme_config();
		test_random(950);
		repeat (50) @(posedge clk);
		if (err_cnt == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
